### rtl/tmc_pkg.sv
// Package for the TRS matrix composer: sizes, datapath types and the CORDIC arctangent table.
// It has no dependencies. Every module of the block imports it.
package tmc_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int IDX_W         = $clog2(ATAN_ENTRIES);
    localparam int XW            = 34;
    localparam int ZW            = 33;
    localparam int NUM_PIPE      = CORDIC_STAGES + 5;

    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(34'sh26DD3B6A);

    typedef logic signed [XW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        zval_t z;
    } lane_t;

    typedef struct packed {
        logic [2:0][1:0]  quad;
        logic [2:0][15:0] scale;
        logic [2:0][31:0] pos;
    } side_t;

    function automatic logic [31:0] atan_phase(input logic [IDX_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [XW:0] v);
        logic signed [XW:0] r;
        r = (v + (XW+1)'(16384)) >>> 15;
        if (r > (XW+1)'(32767))
            return 16'sh7FFF;
        else if (r < -(XW+1)'(32768))
            return 16'sh8000;
        else
            return r[15:0];
    endfunction

endpackage

### rtl/tmc_cordic_cell.sv
// One rotation stage of the three-lane CORDIC chain.
// Depends on tmc_pkg for lane types and the arctangent table.
module tmc_cordic_cell (
    input  logic                     clk,
    input  logic                     en,
    input  logic [tmc_pkg::IDX_W-1:0] idx,
    input  tmc_pkg::lane_t [2:0]     lane_in,
    input  tmc_pkg::side_t           side_in,
    output tmc_pkg::lane_t [2:0]     lane_out,
    output tmc_pkg::side_t           side_out
);
    import tmc_pkg::*;

    lane_t [2:0] lane_next;
    lane_t [2:0] lane_reg;
    side_t       side_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            cval_t dx;
            cval_t dy;
            zval_t at;
            dx = lane_in[l].y >>> idx;
            dy = lane_in[l].x >>> idx;
            at = zval_t'(atan_phase(idx));
            if (!lane_in[l].z[ZW-1])
            begin
                lane_next[l].x = lane_in[l].x - dx;
                lane_next[l].y = lane_in[l].y + dy;
                lane_next[l].z = lane_in[l].z - at;
            end
            else
            begin
                lane_next[l].x = lane_in[l].x + dx;
                lane_next[l].y = lane_in[l].y - dy;
                lane_next[l].z = lane_in[l].z + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign lane_out = lane_reg;
    assign side_out = side_reg;

endmodule

### rtl/tmc_matrix_calc.sv
// Four-stage back end: quadrant fix-up and Q1.15 rounding, pair products,
// Q45 entries, then scaling and rounding to Q16.16. Depends on tmc_pkg.
module tmc_matrix_calc (
    input  logic                 clk,
    input  logic                 en,
    input  tmc_pkg::lane_t [2:0] lane_in,
    input  tmc_pkg::side_t       side_in,
    output logic [8:0][31:0]     entry_out,
    output logic [2:0][31:0]     tr_out
);
    import tmc_pkg::*;

    logic signed [2:0][15:0] cos_reg, sin_reg;
    logic [2:0][15:0]        scale_a_reg, scale_b_reg, scale_c_reg;
    logic [2:0][31:0]        pos_a_reg, pos_b_reg, pos_c_reg, pos_d_reg;
    logic signed [15:0]      s2_b_reg, s3_b_reg;
    logic signed [31:0]      c1c3_reg, s1s2_reg, c2s3_reg, c1s2_reg, c3s1_reg;
    logic signed [31:0]      c1s3_reg, c2c3_reg, s1s3_reg, c2s1_reg, c1c2_reg;
    logic signed [8:0][47:0] q45_reg;
    logic [8:0][31:0]        entry_reg;
    logic signed [2:0][15:0] cos_next, sin_next;
    logic signed [8:0][47:0] q45_next;
    logic [8:0][31:0]        entry_next;
    logic signed [15:0]      c1, s1, c2, s2, c3, s3;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic signed [XW:0] xe;
            logic signed [XW:0] ye;
            xe = (XW+1)'(lane_in[l].x);
            ye = (XW+1)'(lane_in[l].y);
            case (side_in.quad[l])
                2'd0:
                begin
                    cos_next[l] = to_q15(xe);
                    sin_next[l] = to_q15(ye);
                end
                2'd1:
                begin
                    cos_next[l] = to_q15(-ye);
                    sin_next[l] = to_q15(xe);
                end
                2'd2:
                begin
                    cos_next[l] = to_q15(-xe);
                    sin_next[l] = to_q15(-ye);
                end
                default:
                begin
                    cos_next[l] = to_q15(ye);
                    sin_next[l] = to_q15(-xe);
                end
            endcase
        end
    end

    assign c1 = cos_reg[1];
    assign s1 = sin_reg[1];
    assign c2 = cos_reg[0];
    assign s2 = sin_reg[0];
    assign c3 = cos_reg[2];
    assign s3 = sin_reg[2];

    always_comb
    begin
        q45_next[0] = (48'(c1c3_reg) <<< 15) + 48'(s1s2_reg) * 48'(s3_b_reg);
        q45_next[1] = 48'(c2s3_reg) <<< 15;
        q45_next[2] = 48'(c1s2_reg) * 48'(s3_b_reg) - (48'(c3s1_reg) <<< 15);
        q45_next[3] = 48'(c3s1_reg) * 48'(s2_b_reg) - (48'(c1s3_reg) <<< 15);
        q45_next[4] = 48'(c2c3_reg) <<< 15;
        q45_next[5] = 48'(c1c3_reg) * 48'(s2_b_reg) + (48'(s1s3_reg) <<< 15);
        q45_next[6] = 48'(c2s1_reg) <<< 15;
        q45_next[7] = -(48'(s2_b_reg) <<< 30);
        q45_next[8] = 48'(c1c2_reg) <<< 15;
    end

    always_comb
    begin
        for (int e = 0; e < 9; e++)
        begin
            logic signed [63:0] prod;
            logic signed [15:0] sc;
            sc   = scale_c_reg[e / 3];
            prod = 64'(signed'(q45_reg[e])) * 64'(sc) + (64'sd1 <<< 36);
            prod = prod >>> 37;
            entry_next[e] = prod[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            scale_a_reg <= side_in.scale;
            pos_a_reg   <= side_in.pos;

            c1c3_reg    <= c1 * c3;
            s1s2_reg    <= s1 * s2;
            c2s3_reg    <= c2 * s3;
            c1s2_reg    <= c1 * s2;
            c3s1_reg    <= c3 * s1;
            c1s3_reg    <= c1 * s3;
            c2c3_reg    <= c2 * c3;
            s1s3_reg    <= s1 * s3;
            c2s1_reg    <= c2 * s1;
            c1c2_reg    <= c1 * c2;
            s2_b_reg    <= s2;
            s3_b_reg    <= s3;
            scale_b_reg <= scale_a_reg;
            pos_b_reg   <= pos_a_reg;

            q45_reg     <= q45_next;
            scale_c_reg <= scale_b_reg;
            pos_c_reg   <= pos_b_reg;

            entry_reg   <= entry_next;
            pos_d_reg   <= pos_c_reg;
        end
    end

    assign entry_out = entry_reg;
    assign tr_out    = pos_d_reg;

endmodule

### rtl/trs_matrix_compose_unit.sv
// Usage: one input transaction carries three binary angles, three Q8.8
// scales and a Q16.16 position; one output transaction carries the three
// scaled rotation columns and the translation column, all Q16.16.
// Both channels use valid and stall; a transaction moves on a clock edge
// with valid high and stall low.
// Stages, in order: angle preparation, a stage for each CORDIC cell, and
// the back-end stages of rounding, products, entry sums and scaling.
// Throughput is one transaction per cycle. The whole pipeline advances
// together; it holds only while the output is valid and stalled, and
// in_stall follows that condition.
// Reset clears all valid flags; payload registers are not reset.
// Depends on tmc_pkg, tmc_cordic_cell and tmc_matrix_calc.
module trs_matrix_compose_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] angle_x,
    input  logic [15:0] angle_y,
    input  logic [15:0] angle_z,
    input  logic [15:0] scale_x,
    input  logic [15:0] scale_y,
    input  logic [15:0] scale_z,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] col0_x,
    output logic [31:0] col0_y,
    output logic [31:0] col0_z,
    output logic [31:0] col1_x,
    output logic [31:0] col1_y,
    output logic [31:0] col1_z,
    output logic [31:0] col2_x,
    output logic [31:0] col2_y,
    output logic [31:0] col2_z,
    output logic [31:0] tr_x,
    output logic [31:0] tr_y,
    output logic [31:0] tr_z
);
    import tmc_pkg::*;

    logic                adv;
    logic [NUM_PIPE-1:0] vld_reg;
    logic [NUM_PIPE-1:0] vld_next;
    lane_t [2:0]         prep_next;
    lane_t [2:0]         prep_reg;
    side_t               side_next;
    side_t               side_reg;
    lane_t [CORDIC_STAGES:0][2:0] chain_lane;
    side_t [CORDIC_STAGES:0]      chain_side;
    logic [8:0][31:0]    entry;
    logic [2:0][31:0]    tr;
    logic [2:0][15:0]    angles;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign angles   = {angle_z, angle_y, angle_x};

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [47:0] ext;
            logic [31:0] phase;
            logic [31:0] rnd;
            logic [31:0] res;
            ext   = {{32{angles[l][15]}}, angles[l]};
            phase = 32'(ext << (32 - ANGLE_BITS));
            rnd   = phase + 32'h20000000;
            res   = phase - {rnd[31:30], 30'd0};
            side_next.quad[l] = rnd[31:30];
            prep_next[l].x    = CORDIC_GAIN;
            prep_next[l].y    = '0;
            prep_next[l].z    = ZW'(signed'(res));
        end
        side_next.scale = {scale_z, scale_y, scale_x};
        side_next.pos   = {pos_z, pos_y, pos_x};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_reg <= prep_next;
            side_reg <= side_next;
        end
    end

    assign chain_lane[0] = prep_reg;
    assign chain_side[0] = side_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        tmc_cordic_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .idx      (IDX_W'(i)),
            .lane_in  (chain_lane[i]),
            .side_in  (chain_side[i]),
            .lane_out (chain_lane[i+1]),
            .side_out (chain_side[i+1])
        );
    end

    tmc_matrix_calc u_calc (
        .clk       (clk),
        .en        (adv),
        .lane_in   (chain_lane[CORDIC_STAGES]),
        .side_in   (chain_side[CORDIC_STAGES]),
        .entry_out (entry),
        .tr_out    (tr)
    );

    assign vld_next = adv ? {vld_reg[NUM_PIPE-2:0], in_valid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign out_valid = vld_reg[NUM_PIPE-1];
    assign col0_x = entry[0];
    assign col0_y = entry[1];
    assign col0_z = entry[2];
    assign col1_x = entry[3];
    assign col1_y = entry[4];
    assign col1_z = entry[5];
    assign col2_x = entry[6];
    assign col2_y = entry[7];
    assign col2_z = entry[8];
    assign tr_x   = tr[0];
    assign tr_y   = tr[1];
    assign tr_z   = tr[2];

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid flags moved while the output was stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_shift_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[NUM_PIPE-1:1] == $past(vld_reg[NUM_PIPE-2:0]))
        else $error("valid flags did not shift by one stage on advance");
`endif

endmodule
